FILE: sv/cpmt_pkg.sv
// ----------------------------------------------------------------------------
// cpmt_pkg: shared types and constants for the prefix match table
// Request codes, the word handed from cell to cell and the prefix mask helper.
// ----------------------------------------------------------------------------
package cpmt_pkg;

  localparam int ADDR_W        = 128;
  localparam int HALF_W        = 64;
  localparam int V4_W          = 32;
  localparam int PREFIX_W      = 8;
  localparam int REQ_W         = 2;
  localparam int ENTRY_COUNT_W = 6;

  // request codes; the spare code leaves the table untouched
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_code_t;

  // word passed down the chain of cells, one cell per cycle
  typedef struct packed {
    logic                valid;
    logic [REQ_W-1:0]    req_type;
    logic                is_v6;
    logic [HALF_W-1:0]   addr_hi;
    logic [HALF_W-1:0]   addr_lo;
    logic [PREFIX_W-1:0] prefix_len;
    logic                matched;
  } link_t;

  // leading-ones mask over a 128-bit address; prefixes past the width saturate,
  // and the top 32 bits give the ipv4 mask with the same clamp
  function automatic logic [ADDR_W-1:0] lead_mask(input logic [PREFIX_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int j = 0; j < ADDR_W; j++) begin
      m[j] = (PREFIX_W'(ADDR_W - 1 - j) < plen);
    end
    return m;
  endfunction

endpackage

FILE: sv/cpmt_req_if.sv
// ----------------------------------------------------------------------------
// cpmt_req_if: request channel
// Valid/ready channel carrying clear, append and lookup words.
// ----------------------------------------------------------------------------
interface cpmt_req_if;
  logic                          valid;
  logic                          ready;
  logic [cpmt_pkg::REQ_W-1:0]    req_type;
  logic                          is_v6;
  logic [cpmt_pkg::HALF_W-1:0]   addr_hi;
  logic [cpmt_pkg::HALF_W-1:0]   addr_lo;
  logic [cpmt_pkg::PREFIX_W-1:0] prefix_len;

  modport source (output valid, req_type, is_v6, addr_hi, addr_lo, prefix_len,
                  input ready);
  modport sink   (input valid, req_type, is_v6, addr_hi, addr_lo, prefix_len,
                  output ready);
endinterface

FILE: sv/cpmt_rsp_if.sv
// ----------------------------------------------------------------------------
// cpmt_rsp_if: result channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface cpmt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               matched;
  logic                               dropped;
  logic [cpmt_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, matched, dropped, entry_count, input ready);
  modport sink   (input valid, matched, dropped, entry_count, output ready);
endinterface

FILE: sv/cidr_prefix_match_table.sv
// ----------------------------------------------------------------------------
// cidr_prefix_match_table: ipv4/ipv6 prefix range table
// Stores up to TABLE_ENTRIES ranges in a chain of cells and answers clear,
// append and lookup requests with one result word each.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An accepted word walks the chain of
// TABLE_ENTRIES cells, one cell per clock, and its result is registered at the
// tail. The block stays busy until that result is taken, and the next word can
// be accepted in the cycle after that, so a stall on the result side holds off
// the next request. Lookups compare the address against every stored range of
// the same family; ipv4 uses the low 32 bits of addr_lo and treats prefixes
// above 32 as 32. An append to a full table is refused and flagged with
// dropped; entry_count reports the fill level after each word, modulo 64. No
// word is taken during reset, and no clearing pass is needed after it.
module cidr_prefix_match_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  cpmt_req_if.sink          req,
  cpmt_rsp_if.source        rsp
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic                                 busy;
  logic [CW-1:0]                        count;
  logic [CW-1:0]                        count_next;
  logic                                 rsp_valid;
  logic                                 rsp_matched;
  logic                                 rsp_dropped;
  logic [cpmt_pkg::ENTRY_COUNT_W-1:0]   rsp_count;
  logic                                 accept;
  logic                                 full;
  cpmt_pkg::link_t                      links [0:TABLE_ENTRIES];
  cpmt_pkg::link_t                      tail;

  assign req.ready = !busy && !rst;
  assign accept    = req.valid && !busy && !rst;
  assign full      = (count == CW'(TABLE_ENTRIES));

  // word entering the first cell
  always_comb begin
    links[0].valid      = accept;
    links[0].req_type   = req.req_type;
    links[0].is_v6      = req.is_v6;
    links[0].addr_hi    = req.addr_hi;
    links[0].addr_lo    = req.addr_lo;
    links[0].prefix_len = req.prefix_len;
    links[0].matched    = 1'b0;
  end

  // chain of entry cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cpmt_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .INDEX         (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign tail = links[TABLE_ENTRIES];

  // fill level once the word leaves the chain
  always_comb begin
    case (tail.req_type)
      cpmt_pkg::REQ_CLEAR:  count_next = '0;
      cpmt_pkg::REQ_APPEND: count_next = full ? count : count + CW'(1);
      default:              count_next = count;
    endcase
  end

  // fill count, busy flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (tail.valid) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
    if (tail.valid) begin
      rsp_matched <= tail.matched;
      rsp_dropped <= (tail.req_type == cpmt_pkg::REQ_APPEND) && full;
      rsp_count   <= cpmt_pkg::ENTRY_COUNT_W'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.matched     = rsp_matched;
  assign rsp.dropped     = rsp_dropped;
  assign rsp.entry_count = rsp_count;

endmodule

FILE: sv/cpmt_cell.sv
// ----------------------------------------------------------------------------
// cpmt_cell: one table entry
// Holds a single range, takes an append aimed at its slot, compares lookups
// against its range and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module cpmt_cell #(
  parameter int TABLE_ENTRIES = 32,
  parameter int INDEX         = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     count,
  input  cpmt_pkg::link_t                        link_in,
  output cpmt_pkg::link_t                        link_out
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic                          family;
  logic [cpmt_pkg::HALF_W-1:0]   base_hi;
  logic [cpmt_pkg::HALF_W-1:0]   base_lo;
  logic [cpmt_pkg::PREFIX_W-1:0] prefix;

  logic [cpmt_pkg::ADDR_W-1:0]   mask;
  logic [cpmt_pkg::ADDR_W-1:0]   diff;
  logic                          occupied;
  logic                          range_hit;
  logic                          hit;
  logic                          write_en;
  cpmt_pkg::link_t               link;

  // slot is in use while its index lies below the fill count
  assign occupied = (CW'(INDEX) < count);
  assign write_en = link_in.valid && (link_in.req_type == cpmt_pkg::REQ_APPEND)
                    && (count == CW'(INDEX));

  // entry store, written only by an append aimed at this slot
  always_ff @(posedge clk) begin
    if (write_en) begin
      family  <= link_in.is_v6;
      base_hi <= link_in.addr_hi;
      base_lo <= link_in.addr_lo;
      prefix  <= link_in.prefix_len;
    end
  end

  // masked compare of leading bits
  always_comb begin
    mask = cpmt_pkg::lead_mask(prefix);
    diff = {base_hi, base_lo} ^ {link_in.addr_hi, link_in.addr_lo};
    if (family) begin
      range_hit = ((diff & mask) == '0);
    end else begin
      range_hit = ((diff[cpmt_pkg::V4_W-1:0]
                    & mask[cpmt_pkg::ADDR_W-1 -: cpmt_pkg::V4_W]) == '0);
    end
    hit = link_in.valid && (link_in.req_type == cpmt_pkg::REQ_LOOKUP) && occupied
          && (family == link_in.is_v6) && range_hit;
  end

  // word register towards the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      link.valid <= 1'b0;
    end else begin
      link.valid <= link_in.valid;
    end
    link.req_type   <= link_in.req_type;
    link.is_v6      <= link_in.is_v6;
    link.addr_hi    <= link_in.addr_hi;
    link.addr_lo    <= link_in.addr_lo;
    link.prefix_len <= link_in.prefix_len;
    link.matched    <= link_in.matched | hit;
  end

  assign link_out = link;

endmodule

FILE: sv/cpmt_checker.sv
// ----------------------------------------------------------------------------
// cpmt_checker: port-level checks for the prefix match table
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module cpmt_checker #(
  parameter int TABLE_ENTRIES = 32
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               rsp_matched,
  input logic                               rsp_dropped,
  input logic [cpmt_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);

  // a result never reports both a hit and a refused append
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_matched && rsp_dropped))
    else $error("matched and dropped both set");

  // a refused append only happens on a full table
  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_dropped)
      |-> (rsp_entry_count == cpmt_pkg::ENTRY_COUNT_W'(TABLE_ENTRIES)))
    else $error("dropped with table not full");

  // one word at a time: no new word straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second word taken while busy");

  // a stalled result holds its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready)
      |=> (rsp_valid && $stable(rsp_matched) && $stable(rsp_dropped)
           && $stable(rsp_entry_count)))
    else $error("result changed while stalled");

endmodule

bind cidr_prefix_match_table cpmt_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_cpmt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_matched     (rsp.matched),
  .rsp_dropped     (rsp.dropped),
  .rsp_entry_count (rsp.entry_count)
);

FILE: tb/cidr_prefix_match_table_tb.sv
// ----------------------------------------------------------------------------
// cidr_prefix_match_table_tb: self-checking bench for the prefix match table
// Drives clear, append, lookup and spare-code words through the request channel with
// random gaps and stalls. A shadow copy of the range table works out every
// result word, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module cidr_prefix_match_table_tb;

  localparam int TABLE_ENTRIES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_IDLE      = 18;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [cpmt_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic                               matched;
    logic                               dropped;
    logic [cpmt_pkg::ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

  logic clk;
  logic rst;

  cpmt_req_if req_ch();
  cpmt_rsp_if rsp_ch();

  cidr_prefix_match_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the range table
  logic                          shadow_v6   [TABLE_ENTRIES];
  logic [cpmt_pkg::ADDR_W-1:0]   shadow_base [TABLE_ENTRIES];
  logic [cpmt_pkg::PREFIX_W-1:0] shadow_plen [TABLE_ENTRIES];
  int                            shadow_count;

  result_t due_results[$];

  bit idle_on;
  int hold_off_cycles;
  int mismatch_count;
  int idle_cycles;
  int words_sent;
  int hits_seen;
  int drops_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // prefix clamped to the width of its family
  function automatic int clamp_prefix(input logic v6,
                                      input logic [cpmt_pkg::PREFIX_W-1:0] plen);
    int lim;
    lim = v6 ? cpmt_pkg::ADDR_W : cpmt_pkg::V4_W;
    return (int'(plen) > lim) ? lim : int'(plen);
  endfunction

  // bits of {addr_hi, addr_lo} that a range compares
  function automatic logic [cpmt_pkg::ADDR_W-1:0] range_mask(
      input logic v6, input logic [cpmt_pkg::PREFIX_W-1:0] plen);
    int p;
    logic [cpmt_pkg::V4_W-1:0] m32;
    logic [cpmt_pkg::ADDR_W-1:0] m128;
    p = clamp_prefix(v6, plen);
    if (p == 0) return '0;
    if (v6) begin
      m128 = {cpmt_pkg::ADDR_W{1'b1}};
      return m128 << (cpmt_pkg::ADDR_W - p);
    end
    m32 = {cpmt_pkg::V4_W{1'b1}};
    m32 = m32 << (cpmt_pkg::V4_W - p);
    return {{(cpmt_pkg::ADDR_W - cpmt_pkg::V4_W){1'b0}}, m32};
  endfunction

  // applies one word to the shadow table and gives the result word it causes
  function automatic result_t table_step(input logic [cpmt_pkg::REQ_W-1:0] code,
                                         input logic v6,
                                         input logic [cpmt_pkg::HALF_W-1:0] hi,
                                         input logic [cpmt_pkg::HALF_W-1:0] lo,
                                         input logic [cpmt_pkg::PREFIX_W-1:0] plen);
    result_t r;
    logic [cpmt_pkg::ADDR_W-1:0] m;
    r = '0;
    case (code)
      cpmt_pkg::REQ_CLEAR: shadow_count = 0;
      cpmt_pkg::REQ_APPEND: begin
        if (shadow_count < TABLE_ENTRIES) begin
          shadow_v6[shadow_count]   = v6;
          shadow_base[shadow_count] = {hi, lo};
          shadow_plen[shadow_count] = plen;
          shadow_count++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      cpmt_pkg::REQ_LOOKUP: begin
        for (int k = 0; k < shadow_count; k++) begin
          m = range_mask(v6, shadow_plen[k]);
          if (shadow_v6[k] == v6 && ((({hi, lo} ^ shadow_base[k]) & m) == '0))
            r.matched = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = cpmt_pkg::ENTRY_COUNT_W'(shadow_count);
    return r;
  endfunction

  // offer one word, after a random gap if gaps are enabled, and wait until it is taken
  task automatic send_word(input logic [cpmt_pkg::REQ_W-1:0] code, input logic v6,
                           input logic [cpmt_pkg::HALF_W-1:0] hi,
                           input logic [cpmt_pkg::HALF_W-1:0] lo,
                           input logic [cpmt_pkg::PREFIX_W-1:0] plen);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= code;
    req_ch.is_v6      <= v6;
    req_ch.addr_hi    <= hi;
    req_ch.addr_lo    <= lo;
    req_ch.prefix_len <= plen;
    do @(posedge clk); while (!req_ch.ready);
    due_results.push_back(table_step(code, v6, hi, lo, plen));
    words_sent++;
  endtask

  // sender stops until every result word has come back
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [cpmt_pkg::HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [cpmt_pkg::PREFIX_W-1:0] pick_prefix(input logic v6);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return v6 ? cpmt_pkg::PREFIX_W'(cpmt_pkg::ADDR_W)
                   : cpmt_pkg::PREFIX_W'(cpmt_pkg::V4_W);
      2: return cpmt_pkg::PREFIX_W'($urandom_range(0, 255));
      default: return v6 ? cpmt_pkg::PREFIX_W'($urandom_range(1, 136))
                         : cpmt_pkg::PREFIX_W'($urandom_range(1, 40));
    endcase
  endfunction

  // lookup aimed at a stored range, sometimes with one prefix bit flipped; a random lookup on an empty table
  task automatic send_near_lookup();
    int k, p;
    logic v6;
    logic [cpmt_pkg::ADDR_W-1:0] m, a;
    if (shadow_count == 0) begin
      send_word(cpmt_pkg::REQ_LOOKUP, 1'($urandom), rand64(), rand64(),
                cpmt_pkg::PREFIX_W'($urandom));
      return;
    end
    k  = $urandom_range(0, shadow_count - 1);
    v6 = shadow_v6[k];
    m  = range_mask(v6, shadow_plen[k]);
    a  = (shadow_base[k] & m) | ({rand64(), rand64()} & ~m);
    p  = clamp_prefix(v6, shadow_plen[k]);
    if (p != 0 && $urandom_range(0, 3) == 0)
      a[(v6 ? cpmt_pkg::ADDR_W : cpmt_pkg::V4_W) - 1 - $urandom_range(0, p - 1)] ^= 1'b1;
    send_word(cpmt_pkg::REQ_LOOKUP, v6, a[cpmt_pkg::ADDR_W-1:cpmt_pkg::HALF_W],
              a[cpmt_pkg::HALF_W-1:0], cpmt_pkg::PREFIX_W'($urandom));
  endtask

  // extremes of the fields and each special case
  task automatic test_directed();
    idle_on = 1'b1;
    send_word(cpmt_pkg::REQ_CLEAR, 1'b0, '0, '0, '0);
    // lookups and spare code on an empty table
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b0, '0, '0, '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, '1, '1, '1);
    send_word(REQ_SPARE, 1'b1, '1, '1, '1);
    // zero prefix covers its whole family only
    send_word(cpmt_pkg::REQ_APPEND, 1'b0, '0, 64'h0000_0000_0a00_0000, 8'd0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b0, '1, '1, '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, '0, '0, '0);
    send_word(cpmt_pkg::REQ_CLEAR, 1'b1, '1, '1, '1);
    // ipv4 prefix above 32, upper base bits ignored
    send_word(cpmt_pkg::REQ_APPEND, 1'b0, '1, 64'hffff_ffff_c0a8_0101, 8'd40);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b0, '0, 64'h0000_0000_c0a8_0101, '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b0, '0, 64'h0000_0000_c0a8_0100, '0);
    send_word(cpmt_pkg::REQ_APPEND, 1'b0, '0, '0, 8'd255);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b0, '1, 64'hffff_ffff_0000_0000, '0);
    // full-length ipv6 ranges, one given with an oversized prefix
    send_word(cpmt_pkg::REQ_APPEND, 1'b1, '1, '1, 8'd128);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, '1, '1, '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, '1, 64'hffff_ffff_ffff_fffe, '0);
    send_word(cpmt_pkg::REQ_APPEND, 1'b1, '0, '0, 8'd200);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, '0, '0, '0);
    send_word(cpmt_pkg::REQ_CLEAR, 1'b0, '0, '0, '0);
    // prefixes either side of the half boundary
    send_word(cpmt_pkg::REQ_APPEND, 1'b1, 64'h2001_0db8_0000_0000, 64'h1234_5678_9abc_def0,
              8'd64);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, 64'h2001_0db8_0000_0000, '1, '0);
    send_word(cpmt_pkg::REQ_APPEND, 1'b1, 64'hfe80_0000_0000_0000, 64'h8000_0000_0000_0000,
              8'd65);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, 64'hfe80_0000_0000_0000, '0, '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, 64'hfe80_0000_0000_0000, 64'hbfff_ffff_ffff_ffff,
              '0);
    send_word(REQ_SPARE, 1'b0, '0, '0, '0);
    wait_all_results();
  endtask

  // fill to the limit, then appends are refused
  task automatic test_table_full();
    idle_on = 1'b1;
    send_word(cpmt_pkg::REQ_CLEAR, 1'b0, '0, '0, '0);
    repeat (TABLE_ENTRIES + 3) send_word(cpmt_pkg::REQ_APPEND, 1'($urandom), rand64(),
                                         rand64(), 8'd128);
    send_word(cpmt_pkg::REQ_LOOKUP, shadow_v6[TABLE_ENTRIES-1],
              shadow_base[TABLE_ENTRIES-1][cpmt_pkg::ADDR_W-1:cpmt_pkg::HALF_W],
              shadow_base[TABLE_ENTRIES-1][cpmt_pkg::HALF_W-1:0], '0);
    send_word(cpmt_pkg::REQ_LOOKUP, 1'b1, rand64(), rand64(), '0);
    wait_all_results();
  endtask

  // result side holds off while words are offered with no gaps
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_off_cycles = HOLD_CYCLES;
    send_word(cpmt_pkg::REQ_CLEAR, 1'b0, '0, '0, '0);
    repeat (4) send_word(cpmt_pkg::REQ_APPEND, 1'($urandom), rand64(), rand64(),
                         pick_prefix(1'b1));
    repeat (4) send_near_lookup();
    wait_all_results();
  endtask

  // usually a clear, then a run of appends, then mostly aimed lookups with some noise
  task automatic test_random_traffic(input int n_items);
    int done, n_app, n_look;
    logic v6;
    done = 0;
    while (done < n_items) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) != 0) begin
        send_word(cpmt_pkg::REQ_CLEAR, 1'($urandom), rand64(), rand64(),
                  cpmt_pkg::PREFIX_W'($urandom));
        done++;
      end
      n_app = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      repeat (n_app) begin
        v6 = 1'($urandom);
        send_word(cpmt_pkg::REQ_APPEND, v6, rand64(), rand64(), pick_prefix(v6));
        done++;
      end
      n_look = $urandom_range(4, 20);
      repeat (n_look) begin
        case ($urandom_range(0, 9))
          0: send_word(REQ_SPARE, 1'($urandom), rand64(), rand64(),
                       cpmt_pkg::PREFIX_W'($urandom));
          1: send_word(cpmt_pkg::REQ_LOOKUP, 1'($urandom), rand64(), rand64(),
                       cpmt_pkg::PREFIX_W'($urandom));
          2: begin
            v6 = 1'($urandom);
            send_word(cpmt_pkg::REQ_APPEND, v6, rand64(), rand64(), pick_prefix(v6));
          end
          default: send_near_lookup();
        endcase
        done++;
      end
    end
    wait_all_results();
  endtask

  // result word checker and watchdog
  always @(posedge clk) begin
    result_t exp_r;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatch_count++;
      end else begin
        exp_r = due_results.pop_front();
        if (rsp_ch.matched !== exp_r.matched) begin
          $error("matched: expected %0d, got %0d", exp_r.matched, rsp_ch.matched);
          mismatch_count++;
        end
        if (rsp_ch.dropped !== exp_r.dropped) begin
          $error("dropped: expected %0d, got %0d", exp_r.dropped, rsp_ch.dropped);
          mismatch_count++;
        end
        if (rsp_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 rsp_ch.entry_count);
          mismatch_count++;
        end
        hits_seen  += (rsp_ch.matched === 1'b1);
        drops_seen += (rsp_ch.dropped === 1'b1);
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side ready with random stalls and one long hold-off
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= cpmt_pkg::REQ_CLEAR;
    req_ch.is_v6      <= 1'b0;
    req_ch.addr_hi    <= '0;
    req_ch.addr_lo    <= '0;
    req_ch.prefix_len <= '0;
    idle_on         = 1'b1;
    hold_off_cycles = 0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    words_sent      = 0;
    hits_seen       = 0;
    drops_seen      = 0;
    shadow_count    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random_traffic(1170);

    wait_all_results();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    $display("covered %0d words: clears, appends, lookups and spare codes", words_sent);
    $display("%0d lookups hit a range, %0d appends refused on a full table",
             hits_seen, drops_seen);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
sv/cpmt_pkg.sv
sv/cpmt_req_if.sv
sv/cpmt_rsp_if.sv
sv/cpmt_cell.sv
sv/cidr_prefix_match_table.sv
sv/cpmt_checker.sv
tb/cidr_prefix_match_table_tb.sv
